// ===== hw/rtl/idle_worker_dispatcher_top_macros.svh =====
// ----------------------------------------------------------------------------
// Idle worker dispatcher assertion macros
// Shorthand for the clocked, reset-qualified properties used by the checker.
// ----------------------------------------------------------------------------
`ifndef IDLE_WORKER_DISPATCHER_TOP_MACROS_SVH
`define IDLE_WORKER_DISPATCHER_TOP_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define IDW_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("idle worker dispatcher check failed");

// The consequent must hold in the cycle after the antecedent.
`define IDW_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("idle worker dispatcher check failed");

`endif

// ===== hw/rtl/idw_pkg.sv =====
// ----------------------------------------------------------------------------
// Idle worker dispatcher package
// Widths, request and result codes, and the divider interface types.
// ----------------------------------------------------------------------------
package idw_pkg;

   localparam int MAX_WORKERS = 16;
   localparam int WORKER_W    = 4;
   localparam int COUNT_W     = 5;
   localparam int TASK_W      = 16;
   localparam int KIND_W      = 3;
   localparam int REQ_W       = 2;
   localparam int REQ_DATA_W  = 32;
   localparam int RSP_DATA_W  = 24;
   localparam int CSR_ADDR_W  = 3;
   localparam int CSR_DATA_W  = 32;

   localparam logic [REQ_W-1:0] REQ_MARK_IDLE   = 2'd0;
   localparam logic [REQ_W-1:0] REQ_MARK_ACTIVE = 2'd1;
   localparam logic [REQ_W-1:0] REQ_DISPATCH    = 2'd2;
   localparam logic [REQ_W-1:0] REQ_BALANCE     = 2'd3;

   localparam logic [KIND_W-1:0] KIND_DONE        = 3'd0;
   localparam logic [KIND_W-1:0] KIND_LOCAL       = 3'd1;
   localparam logic [KIND_W-1:0] KIND_IDLE_WORKER = 3'd2;
   localparam logic [KIND_W-1:0] KIND_ROUND_ROBIN = 3'd3;
   localparam logic [KIND_W-1:0] KIND_NONE        = 3'd4;

   localparam logic [0:0] REG_WORKER_COUNT = 1'd0;

   typedef struct packed {
      logic               start;
      logic [TASK_W-1:0]  dividend;
      logic [COUNT_W-1:0] divisor;
   } div_request_type;

   typedef struct packed {
      logic               done;
      logic [TASK_W-1:0]  quotient;
      logic [COUNT_W-1:0] remainder;
   } div_status_type;

endpackage

// ===== hw/rtl/idle_worker_dispatcher_top.sv =====
// ----------------------------------------------------------------------------
// Idle worker dispatcher
// Keeps an idle flag per worker and a round-robin cursor, places dispatched
// tasks on idle workers and splits a queue over idle workers on balance.
//
//   Channel  Direction  Handshake          Contents
//   req_     in         tvalid/tready      request kind in tuser, fields in tdata
//   rsp_     out        tvalid/tready      result kind in tuser, tlast on final
//   csr_     in         psel/penable       worker_count at byte address 0
//
// Mark requests and local dispatches pass through the result state to the
// result register. A scanning dispatch reduces the scan start in the shared
// 16-step serial divider, then checks one flag per cycle.
// Balance adds the share division, then one grant per cycle unless a result is held.
// Reset restores the count, flags and cursor at once.
// The block is ready only between requests; a held result stalls the sequencer.
// ----------------------------------------------------------------------------
module idle_worker_dispatcher_top (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   output logic                           req_tready,
   // [3:0] worker_index, [4] caller_is_worker, [5] caller_queue_empty,
   // [9:6] start_hint, [25:10] task_count, [31:26] zero
   input  logic [idw_pkg::REQ_DATA_W-1:0] req_tdata,
   // [1:0] req_type
   input  logic [idw_pkg::REQ_W-1:0]      req_tuser,
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   // [3:0] target_worker, [19:4] donate_count, [23:20] zero
   output logic [idw_pkg::RSP_DATA_W-1:0] rsp_tdata,
   // [2:0] result_kind
   output logic [idw_pkg::KIND_W-1:0]     rsp_tuser,
   output logic                           rsp_tlast,
   input  logic                           csr_psel,
   input  logic                           csr_penable,
   input  logic                           csr_pwrite,
   input  logic [idw_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [idw_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic [idw_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic                           csr_pready
);
   import idw_pkg::*;

   typedef enum logic [2:0] {
      S_IDLE,
      S_REDUCE,
      S_SCAN,
      S_DIVIDE,
      S_RESULT,
      S_GRANTS
   } state_type;

   function automatic logic [MAX_WORKERS-1:0] idle_mask(input logic [COUNT_W-1:0] n);
      logic [MAX_WORKERS-1:0] mask;
      for (int j = 0; j < MAX_WORKERS; j++) begin
         mask[j] = (COUNT_W'(j) < n);
      end
      return mask;
   endfunction

   state_type              state_ff, state_in;
   logic [COUNT_W-1:0]     count_ff, count_in;
   logic [MAX_WORKERS-1:0] flags_ff, flags_in;
   logic [WORKER_W-1:0]    cursor_ff, cursor_in;
   logic [WORKER_W-1:0]    widx_ff, widx_in;
   logic                   worker_ff, worker_in;
   logic                   balance_ff, balance_in;
   logic                   skip_ff, skip_in;
   logic [TASK_W-1:0]      tasks_ff, tasks_in;
   logic [COUNT_W-1:0]     maxg_ff, maxg_in;
   logic [WORKER_W-1:0]    idx_ff, idx_in;
   logic [COUNT_W-1:0]     scan_ff, scan_in;
   logic [COUNT_W-1:0]     grants_ff, grants_in;
   logic [WORKER_W-1:0]    grant_ff [MAX_WORKERS];
   logic                   grant_we;
   logic [TASK_W-1:0]      share_ff, share_in;
   logic [COUNT_W-1:0]     extra_ff, extra_in;
   logic [WORKER_W-1:0]    emit_ff, emit_in;
   logic [KIND_W-1:0]      pend_kind_ff, pend_kind_in;
   logic [WORKER_W-1:0]    pend_tgt_ff, pend_tgt_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [KIND_W-1:0]      rsp_kind_ff, rsp_kind_in;
   logic [WORKER_W-1:0]    rsp_tgt_ff, rsp_tgt_in;
   logic [TASK_W-1:0]      rsp_donate_ff, rsp_donate_in;
   logic                   rsp_last_ff, rsp_last_in;

   div_request_type div_req;
   div_status_type  div_status;

   logic [REQ_W-1:0]    in_type;
   logic [WORKER_W-1:0] in_widx;
   logic                in_is_worker;
   logic                in_q_empty;
   logic [WORKER_W-1:0] in_hint;
   logic [TASK_W-1:0]   in_tasks;
   logic                req_accept;
   logic                csr_write;
   logic [COUNT_W-1:0]  csr_count;
   logic [COUNT_W-1:0]  new_count;
   logic                slot_free;
   logic                scan_end;
   logic                skip_hit;
   logic [WORKER_W-1:0] idx_next;
   logic [WORKER_W-1:0] cursor_next;
   logic                grant_final;

   assign in_type      = req_tuser;
   assign in_widx      = req_tdata[3:0];
   assign in_is_worker = req_tdata[4];
   assign in_q_empty   = req_tdata[5];
   assign in_hint      = req_tdata[9:6];
   assign in_tasks     = req_tdata[25:10];

   assign req_tready = (state_ff == S_IDLE);
   assign req_accept = req_tvalid & req_tready;
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel & csr_penable & csr_pwrite & csr_pready &
                       (csr_paddr[2] == REG_WORKER_COUNT);
   assign csr_count  = csr_pwdata[COUNT_W-1:0];
   assign csr_prdata = (csr_paddr[2] == REG_WORKER_COUNT) ?
                       CSR_DATA_W'(count_ff) : '0;

   assign new_count = (csr_count == '0) ? COUNT_W'(1) :
                      (csr_count > COUNT_W'(MAX_WORKERS)) ? COUNT_W'(MAX_WORKERS) :
                      csr_count;

   assign slot_free   = !rsp_valid_ff || rsp_tready;
   assign skip_hit    = skip_ff && (idx_ff == widx_ff);
   assign scan_end    = (scan_ff == count_ff) || (balance_ff && (grants_ff == maxg_ff));
   assign idx_next    = (({1'b0, idx_ff} + 1'b1) == count_ff) ? '0 : idx_ff + 1'b1;
   assign cursor_next = (({1'b0, cursor_ff} + 1'b1) == count_ff) ? '0 : cursor_ff + 1'b1;
   assign grant_final = (({1'b0, emit_ff} + 1'b1) == grants_ff);

   idw_divider u_divider (
      .clock      (clock),
      .reset      (reset),
      .div_req    (div_req),
      .div_status (div_status)
   );

   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      flags_in      = flags_ff;
      cursor_in     = cursor_ff;
      widx_in       = widx_ff;
      worker_in     = worker_ff;
      balance_in    = balance_ff;
      skip_in       = skip_ff;
      tasks_in      = tasks_ff;
      maxg_in       = maxg_ff;
      idx_in        = idx_ff;
      scan_in       = scan_ff;
      grants_in     = grants_ff;
      grant_we      = 1'b0;
      share_in      = share_ff;
      extra_in      = extra_ff;
      emit_in       = emit_ff;
      pend_kind_in  = pend_kind_ff;
      pend_tgt_in   = pend_tgt_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_kind_in   = rsp_kind_ff;
      rsp_tgt_in    = rsp_tgt_ff;
      rsp_donate_in = rsp_donate_ff;
      rsp_last_in   = rsp_last_ff;
      div_req       = '0;

      unique case (state_ff)
         S_IDLE: begin
            if (req_accept) begin
               widx_in    = in_widx;
               worker_in  = in_is_worker;
               tasks_in   = in_tasks;
               balance_in = 1'b0;
               unique case (in_type)
                  REQ_MARK_IDLE, REQ_MARK_ACTIVE: begin
                     if ({1'b0, in_widx} < count_ff) begin
                        flags_in[in_widx] = (in_type == REQ_MARK_IDLE);
                     end
                     pend_kind_in = KIND_DONE;
                     pend_tgt_in  = '0;
                     state_in     = S_RESULT;
                  end
                  REQ_DISPATCH: begin
                     if (in_is_worker && in_q_empty) begin
                        pend_kind_in = KIND_LOCAL;
                        pend_tgt_in  = in_widx;
                        state_in     = S_RESULT;
                     end else begin
                        skip_in          = in_is_worker && ({1'b0, in_widx} < count_ff);
                        div_req.start    = 1'b1;
                        div_req.dividend = TASK_W'(in_is_worker ? in_widx : in_hint);
                        div_req.divisor  = count_ff;
                        state_in         = S_REDUCE;
                     end
                  end
                  REQ_BALANCE: begin
                     if ((in_tasks < TASK_W'(2)) || (count_ff < COUNT_W'(2))) begin
                        pend_kind_in = KIND_NONE;
                        pend_tgt_in  = '0;
                        state_in     = S_RESULT;
                     end else begin
                        balance_in = 1'b1;
                        skip_in    = 1'b1;
                        if ((in_tasks - 1'b1) < TASK_W'(count_ff - 1'b1)) begin
                           maxg_in = COUNT_W'(in_tasks - 1'b1);
                        end else begin
                           maxg_in = count_ff - 1'b1;
                        end
                        div_req.start    = 1'b1;
                        div_req.dividend = TASK_W'(in_widx);
                        div_req.divisor  = count_ff;
                        state_in         = S_REDUCE;
                     end
                  end
               endcase
            end
         end
         S_REDUCE: begin
            if (div_status.done) begin
               idx_in    = div_status.remainder[WORKER_W-1:0];
               scan_in   = '0;
               grants_in = '0;
               state_in  = S_SCAN;
            end
         end
         S_SCAN: begin
            if (scan_end) begin
               if (balance_ff) begin
                  if (grants_ff == '0) begin
                     pend_kind_in = KIND_NONE;
                     pend_tgt_in  = '0;
                     state_in     = S_RESULT;
                  end else begin
                     div_req.start    = 1'b1;
                     div_req.dividend = tasks_ff;
                     div_req.divisor  = grants_ff + 1'b1;
                     state_in         = S_DIVIDE;
                  end
               end else if (worker_ff) begin
                  pend_kind_in = KIND_LOCAL;
                  pend_tgt_in  = widx_ff;
                  state_in     = S_RESULT;
               end else begin
                  pend_kind_in = KIND_ROUND_ROBIN;
                  pend_tgt_in  = cursor_ff;
                  cursor_in    = cursor_next;
                  state_in     = S_RESULT;
               end
            end else begin
               scan_in = scan_ff + 1'b1;
               idx_in  = idx_next;
               if (!skip_hit && flags_ff[idx_ff]) begin
                  flags_in[idx_ff] = 1'b0;
                  if (balance_ff) begin
                     grant_we  = 1'b1;
                     grants_in = grants_ff + 1'b1;
                  end else begin
                     pend_kind_in = KIND_IDLE_WORKER;
                     pend_tgt_in  = idx_ff;
                     state_in     = S_RESULT;
                  end
               end
            end
         end
         S_DIVIDE: begin
            if (div_status.done) begin
               share_in = div_status.quotient;
               extra_in = div_status.remainder;
               emit_in  = '0;
               state_in = S_GRANTS;
            end
         end
         S_RESULT: begin
            if (slot_free) begin
               rsp_valid_in  = 1'b1;
               rsp_kind_in   = pend_kind_ff;
               rsp_tgt_in    = pend_tgt_ff;
               rsp_donate_in = '0;
               rsp_last_in   = 1'b1;
               state_in      = S_IDLE;
            end
         end
         S_GRANTS: begin
            if (slot_free) begin
               rsp_valid_in  = 1'b1;
               rsp_kind_in   = KIND_IDLE_WORKER;
               rsp_tgt_in    = grant_ff[emit_ff];
               rsp_donate_in = share_ff + TASK_W'({1'b0, emit_ff} < extra_ff);
               rsp_last_in   = grant_final;
               emit_in       = emit_ff + 1'b1;
               if (grant_final) begin
                  state_in = S_IDLE;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      if (csr_write) begin
         count_in  = new_count;
         flags_in  = idle_mask(new_count);
         cursor_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= COUNT_W'(MAX_WORKERS);
         flags_ff     <= idle_mask(COUNT_W'(MAX_WORKERS));
         cursor_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         flags_ff     <= flags_in;
         cursor_ff    <= cursor_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      widx_ff       <= widx_in;
      worker_ff     <= worker_in;
      balance_ff    <= balance_in;
      skip_ff       <= skip_in;
      tasks_ff      <= tasks_in;
      maxg_ff       <= maxg_in;
      idx_ff        <= idx_in;
      scan_ff       <= scan_in;
      grants_ff     <= grants_in;
      share_ff      <= share_in;
      extra_ff      <= extra_in;
      emit_ff       <= emit_in;
      pend_kind_ff  <= pend_kind_in;
      pend_tgt_ff   <= pend_tgt_in;
      rsp_kind_ff   <= rsp_kind_in;
      rsp_tgt_ff    <= rsp_tgt_in;
      rsp_donate_ff <= rsp_donate_in;
      rsp_last_ff   <= rsp_last_in;
   end

   always_ff @(posedge clock) begin
      if (grant_we) begin
         grant_ff[grants_ff[WORKER_W-1:0]] <= idx_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_kind_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tdata  = {(RSP_DATA_W - TASK_W - WORKER_W)'(0), rsp_donate_ff, rsp_tgt_ff};

endmodule

// ===== hw/rtl/idw_divider.sv =====
// ----------------------------------------------------------------------------
// Idle worker dispatcher serial divider
// Restoring divider, one quotient bit per cycle, shared by the scan start
// reduction and the balance share computation.
// ----------------------------------------------------------------------------
module idw_divider (
   input  logic                    clock,
   input  logic                    reset,
   input  idw_pkg::div_request_type div_req,
   output idw_pkg::div_status_type  div_status
);
   import idw_pkg::*;

   localparam int STEP_W = $clog2(TASK_W);

   logic               busy_ff, busy_in;
   logic               done_ff, done_in;
   logic [STEP_W-1:0]  step_ff, step_in;
   logic [TASK_W-1:0]  quot_ff, quot_in;
   logic [COUNT_W-1:0] rem_ff, rem_in;
   logic [COUNT_W-1:0] div_ff, div_in;
   logic [COUNT_W:0]   trial;
   logic               fits;

   always_comb begin
      trial   = {rem_ff, quot_ff[TASK_W-1]};
      fits    = (trial >= {1'b0, div_ff});
      busy_in = busy_ff;
      done_in = 1'b0;
      step_in = step_ff;
      quot_in = quot_ff;
      rem_in  = rem_ff;
      div_in  = div_ff;
      if (div_req.start) begin
         busy_in = 1'b1;
         step_in = '0;
         quot_in = div_req.dividend;
         rem_in  = '0;
         div_in  = div_req.divisor;
      end else if (busy_ff) begin
         quot_in = {quot_ff[TASK_W-2:0], fits};
         rem_in  = fits ? COUNT_W'(trial - {1'b0, div_ff}) : trial[COUNT_W-1:0];
         step_in = step_ff + 1'b1;
         if (step_ff == STEP_W'(TASK_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      step_ff <= step_in;
      quot_ff <= quot_in;
      rem_ff  <= rem_in;
      div_ff  <= div_in;
   end

   assign div_status.done      = done_ff;
   assign div_status.quotient  = quot_ff;
   assign div_status.remainder = rem_ff;

endmodule

// ===== hw/rtl/idw_checker.sv =====
// ----------------------------------------------------------------------------
// Idle worker dispatcher checker
// Port-level properties of the request and result channels.
// ----------------------------------------------------------------------------
`include "idle_worker_dispatcher_top_macros.svh"

module idw_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           req_tvalid,
   input logic                           req_tready,
   input logic                           rsp_tvalid,
   input logic                           rsp_tready,
   input logic [idw_pkg::RSP_DATA_W-1:0] rsp_tdata,
   input logic [idw_pkg::KIND_W-1:0]     rsp_tuser,
   input logic                           rsp_tlast
);
   import idw_pkg::*;

   // A result that is not taken stays unchanged.
   `IDW_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser) && $stable(rsp_tlast))

   // The sequencer is busy in the cycle after it takes a request.
   `IDW_ASSERT_NEXT(a_busy_after_request, clock, reset, req_tvalid && req_tready, !req_tready)

   // Done and none-granted results carry no worker and no tasks.
   `IDW_ASSERT_IMPLY(a_empty_kinds, clock, reset, rsp_tvalid && (rsp_tuser == KIND_DONE || rsp_tuser == KIND_NONE), rsp_tdata == '0 && rsp_tlast)

   // Only grants to idle workers span several results or donate tasks.
   `IDW_ASSERT_IMPLY(a_single_result, clock, reset, rsp_tvalid && rsp_tuser != KIND_IDLE_WORKER, rsp_tlast && rsp_tdata[19:4] == '0)

endmodule

bind idle_worker_dispatcher_top idw_checker u_idw_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser),
   .rsp_tlast  (rsp_tlast)
);

// ===== dv/idle_worker_dispatcher_top_test.sv =====
// ----------------------------------------------------------------------------
// Idle worker dispatcher testbench
// Drives mark, dispatch and balance requests into the dispatcher over a range
// of pool sizes and checks every result against a scoreboard. The scoreboard
// keeps its own idle flags and round-robin cursor. Both stream sides idle at
// random. The result side holds off once for a long stretch. The request side
// waits for every outstanding result once within a phase and after each phase.
// ----------------------------------------------------------------------------
module idle_worker_dispatcher_top_test;
   import idw_pkg::*;

   localparam int CLOCK_PERIOD     = 8;
   localparam int RESET_CYCLES     = 10;
   localparam int WATCHDOG_LIMIT   = 5000;
   localparam int LONG_HOLD_CYCLES = 400;
   localparam int DRAIN_CYCLES     = 64;
   localparam int SETTLE_CYCLES    = 4;
   localparam int PHASE_ITEMS      = 30;
   localparam int MAX_REPORTS      = 10;
   localparam logic [CSR_ADDR_W-1:0] WORKER_COUNT_ADDR = CSR_ADDR_W'(4 * REG_WORKER_COUNT);

   typedef struct packed {
      logic [REQ_W-1:0]    kind;
      logic [WORKER_W-1:0] worker;
      logic                from_worker;
      logic                queue_empty;
      logic [WORKER_W-1:0] hint;
      logic [TASK_W-1:0]   tasks;
   } sched_request_type;

   typedef struct packed {
      logic [KIND_W-1:0]   kind;
      logic [WORKER_W-1:0] target;
      logic [TASK_W-1:0]   donate;
      logic                is_last;
   } sched_result_type;

   class dispatch_scoreboard;
      int unsigned    pool_size;
      logic [MAX_WORKERS-1:0] idle_mask;
      int unsigned    rr_next;
      sched_result_type expected_q[$];
      int unsigned    mismatches;
      int unsigned    checked;
      int unsigned    kind_seen[5];

      function new();
         mismatches = 0;
         checked = 0;
         foreach (kind_seen[k]) kind_seen[k] = 0;
         set_pool_size(MAX_WORKERS);
      endfunction

      // Out-of-range counts are clamped, and a write restarts the pool.
      function void set_pool_size(int unsigned value);
         int unsigned v;
         v = value & 31;
         if (v < 1) v = 1;
         if (v > MAX_WORKERS) v = MAX_WORKERS;
         pool_size = v;
         idle_mask = '0;
         for (int i = 0; i < v; i++) idle_mask[i] = 1'b1;
         rr_next = 0;
      endfunction

      function void push_result(logic [KIND_W-1:0] kind, int unsigned target,
                                int unsigned donate, bit is_last);
         sched_result_type r;
         r.kind = kind;
         r.target = WORKER_W'(target);
         r.donate = TASK_W'(donate);
         r.is_last = is_last;
         expected_q.push_back(r);
      endfunction

      function void note_request(sched_request_type r);
         int unsigned n, w, start, idx, limit, share, extra;
         bit          skip_caller, found;
         int unsigned granted[$];
         n = pool_size;
         w = r.worker;
         case (r.kind)
            REQ_MARK_IDLE, REQ_MARK_ACTIVE: begin
               if (w < n) idle_mask[w] = (r.kind == REQ_MARK_IDLE);
               push_result(KIND_DONE, 0, 0, 1'b1);
            end
            REQ_DISPATCH: begin
               if (r.from_worker && r.queue_empty) begin
                  push_result(KIND_LOCAL, w, 0, 1'b1);
                  return;
               end
               start = r.from_worker ? w % n : r.hint % n;
               skip_caller = r.from_worker && (w < n);
               found = 1'b0;
               for (int i = 0; i < n && !found; i++) begin
                  idx = (start + i) % n;
                  if (!(skip_caller && idx == w) && idle_mask[idx]) begin
                     idle_mask[idx] = 1'b0;
                     push_result(KIND_IDLE_WORKER, idx, 0, 1'b1);
                     found = 1'b1;
                  end
               end
               if (!found) begin
                  if (r.from_worker) begin
                     push_result(KIND_LOCAL, w, 0, 1'b1);
                  end else begin
                     if (rr_next >= n) rr_next = 0;
                     push_result(KIND_ROUND_ROBIN, rr_next, 0, 1'b1);
                     rr_next = (rr_next + 1 >= n) ? 0 : rr_next + 1;
                  end
               end
            end
            default: begin
               if (r.tasks < 2 || n < 2) begin
                  push_result(KIND_NONE, 0, 0, 1'b1);
                  return;
               end
               limit = n - 1;
               if (r.tasks - 1 < limit) limit = r.tasks - 1;
               start = w % n;
               for (int i = 0; i < n && granted.size() < limit; i++) begin
                  idx = (start + i) % n;
                  if (idx != w && idle_mask[idx]) begin
                     idle_mask[idx] = 1'b0;
                     granted.push_back(idx);
                  end
               end
               if (granted.size() == 0) begin
                  push_result(KIND_NONE, 0, 0, 1'b1);
                  return;
               end
               share = r.tasks / (granted.size() + 1);
               extra = r.tasks - share * (granted.size() + 1);
               foreach (granted[k]) begin
                  push_result(KIND_IDLE_WORKER, granted[k], share + ((k < extra) ? 1 : 0),
                              k == granted.size() - 1);
               end
            end
         endcase
      endfunction

      function void report(string what, sched_result_type exp, sched_result_type got);
         mismatches++;
         if (mismatches <= MAX_REPORTS) begin
            $display("%s: expected kind %0d worker %0d donate %0d last %0b,",
                     what, exp.kind, exp.target, exp.donate, exp.is_last);
            $display("   got kind %0d worker %0d donate %0d last %0b",
                     got.kind, got.target, got.donate, got.is_last);
         end
      endfunction

      function void check_result(sched_result_type got);
         sched_result_type exp;
         if (expected_q.size() == 0) begin
            report("Result with no request outstanding", '0, got);
            return;
         end
         exp = expected_q.pop_front();
         checked++;
         if (exp.kind < 5) kind_seen[exp.kind]++;
         if (got.kind !== exp.kind || got.target !== exp.target ||
             got.donate !== exp.donate || got.is_last !== exp.is_last) begin
            report("Result mismatch", exp, got);
         end
      endfunction

      function int unsigned pending();
         return expected_q.size();
      endfunction
   endclass

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata;
   logic [REQ_W-1:0]      req_tuser;
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic [KIND_W-1:0]     rsp_tuser;
   logic                  rsp_tlast;
   logic                  csr_psel;
   logic                  csr_penable;
   logic                  csr_pwrite;
   logic [CSR_ADDR_W-1:0] csr_paddr;
   logic [CSR_DATA_W-1:0] csr_pwdata;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   logic                  quiet;
   logic                  hold_request;
   dispatch_scoreboard    sb;
   int unsigned           sent;
   int unsigned           pool_sizes_run;

   always #(CLOCK_PERIOD / 2) clock = ~clock;

   idle_worker_dispatcher_top u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .rsp_tlast   (rsp_tlast),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   task automatic send_request(sched_request_type r);
      if (!quiet && $urandom_range(0, 3) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 10)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= r.kind;
      req_tdata  <= {6'b0, r.tasks, r.hint, r.queue_empty, r.from_worker, r.worker};
      do @(posedge clock); while (!req_tready);
      sb.note_request(r);
      sent++;
   endtask

   task automatic send_fields(logic [REQ_W-1:0] kind, int unsigned worker, bit from_worker,
                              bit queue_empty, int unsigned hint, int unsigned tasks);
      sched_request_type r;
      r.kind = kind;
      r.worker = WORKER_W'(worker);
      r.from_worker = from_worker;
      r.queue_empty = queue_empty;
      r.hint = WORKER_W'(hint);
      r.tasks = TASK_W'(tasks);
      send_request(r);
   endtask

   function automatic sched_request_type random_request();
      sched_request_type r;
      int unsigned    pick;
      pick = $urandom_range(0, 99);
      if (pick < 30) r.kind = REQ_MARK_IDLE;
      else if (pick < 42) r.kind = REQ_MARK_ACTIVE;
      else if (pick < 77) r.kind = REQ_DISPATCH;
      else r.kind = REQ_BALANCE;
      if ($urandom_range(0, 3) == 0) r.worker = WORKER_W'($urandom_range(0, 15));
      else r.worker = WORKER_W'($urandom_range(0, sb.pool_size - 1));
      r.from_worker = 1'($urandom_range(0, 1));
      r.queue_empty = ($urandom_range(0, 3) == 0);
      r.hint = WORKER_W'($urandom_range(0, 15));
      case ($urandom_range(0, 4))
         0: r.tasks = TASK_W'($urandom_range(0, 3));
         1: r.tasks = TASK_W'($urandom_range(2, 40));
         2: r.tasks = TASK_W'($urandom_range(0, 65535));
         3: r.tasks = TASK_W'(65535 - $urandom_range(0, 3));
         default: r.tasks = TASK_W'($urandom_range(0, 600));
      endcase
      return r;
   endfunction

   task automatic wait_drained();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (sb.pending() != 0);
   endtask

   task automatic configure(int unsigned value);
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= WORKER_COUNT_ADDR;
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      sb.set_pool_size(value);
      pool_sizes_run++;
   endtask

   initial begin : result_sink
      int unsigned      burst_left;
      bit               burst_ready;
      int unsigned      hold_left;
      bit               hold_taken;
      sched_result_type got;
      burst_left = 0;
      burst_ready = 1'b1;
      hold_left = 0;
      hold_taken = 1'b0;
      rsp_tready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_tvalid && rsp_tready) begin
            got.kind = rsp_tuser;
            got.target = rsp_tdata[3:0];
            got.donate = rsp_tdata[19:4];
            got.is_last = rsp_tlast;
            sb.check_result(got);
         end
         if (hold_request && !hold_taken) begin
            hold_taken = 1'b1;
            hold_left = LONG_HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else if (quiet) begin
            rsp_tready <= 1'b1;
         end else begin
            if (burst_left == 0) begin
               burst_ready = ($urandom_range(0, 2) != 0);
               burst_left = $urandom_range(1, 10);
            end
            burst_left--;
            rsp_tready <= burst_ready;
         end
      end
   end

   initial begin : watchdog
      int unsigned stalled;
      stalled = 0;
      forever begin
         @(posedge clock);
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || csr_psel) stalled = 0;
         else stalled++;
         if (stalled >= WATCHDOG_LIMIT) begin
            $display("Watchdog expired: no request or result moved for %0d cycles", stalled);
            $display("idle_worker_dispatcher_top_test: errors");
            $finish;
         end
      end
   end

   initial begin : stimulus
      int unsigned settings[$];
      sb = new();
      sent = 0;
      pool_sizes_run = 1;
      reset        <= 1'b1;
      req_tvalid   <= 1'b0;
      req_tdata    <= '0;
      req_tuser    <= REQ_MARK_IDLE;
      csr_psel     <= 1'b0;
      csr_penable  <= 1'b0;
      csr_pwrite   <= 1'b0;
      csr_paddr    <= '0;
      csr_pwdata   <= '0;
      quiet        <= 1'b0;
      hold_request <= 1'b0;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // A full pool straight out of reset: every request kind, the field
      // extremes, then an exhausted pool.
      send_fields(REQ_MARK_ACTIVE, 15, 0, 0, 0, 0);
      send_fields(REQ_MARK_IDLE, 15, 1, 1, 15, 65535);
      send_fields(REQ_DISPATCH, 0, 1, 1, 0, 0);
      send_fields(REQ_DISPATCH, 0, 1, 0, 0, 0);
      send_fields(REQ_DISPATCH, 3, 0, 0, 15, 0);
      send_fields(REQ_BALANCE, 3, 1, 0, 0, 0);
      send_fields(REQ_BALANCE, 3, 1, 0, 0, 1);
      send_fields(REQ_BALANCE, 15, 1, 0, 0, 2);
      send_fields(REQ_BALANCE, 15, 0, 0, 0, 65535);
      send_fields(REQ_DISPATCH, 5, 1, 0, 0, 0);
      send_fields(REQ_DISPATCH, 5, 0, 0, 7, 0);
      send_fields(REQ_DISPATCH, 5, 0, 1, 0, 0);
      send_fields(REQ_BALANCE, 0, 1, 0, 0, 100);
      send_fields(REQ_MARK_IDLE, 4, 1, 0, 0, 0);
      send_fields(REQ_MARK_IDLE, 9, 1, 0, 0, 0);
      send_fields(REQ_DISPATCH, 4, 1, 0, 0, 0);
      send_fields(REQ_DISPATCH, 15, 0, 1, 15, 65535);
      wait_drained();

      settings = '{1, 0, 2, 31, 5, 16, 17, 9, 3};
      settings.push_back($urandom_range(1, MAX_WORKERS));
      settings.push_back(16);
      foreach (settings[p]) begin
         if (p == settings.size() - 1) quiet <= 1'b1;
         configure(settings[p]);
         if (p == 4) begin
            // Workers beyond the pool: marks change nothing and callers
            // outside the pool scan without skipping anyone.
            send_fields(REQ_MARK_IDLE, 9, 1, 0, 0, 0);
            send_fields(REQ_DISPATCH, 12, 1, 0, 0, 0);
            send_fields(REQ_BALANCE, 7, 0, 0, 0, 9);
         end
         for (int k = 0; k < PHASE_ITEMS; k++) begin
            if (p == 5 && k == 5) hold_request <= 1'b1;
            if (p == 2 && k == 15) wait_drained();
            send_request(random_request());
         end
         wait_drained();
      end
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (sb.pending() != 0) begin
         $display("%0d expected results never arrived", sb.pending());
         sb.mismatches += sb.pending();
      end
      $display("Covered %0d requests over %0d pool sizes; %0d results checked, %0d mismatches.",
               sent, pool_sizes_run, sb.checked, sb.mismatches);
      $display("Results by kind: done %0d, local %0d, idle worker %0d, round robin %0d, none %0d.",
               sb.kind_seen[0], sb.kind_seen[1], sb.kind_seen[2], sb.kind_seen[3],
               sb.kind_seen[4]);
      if (sb.mismatches == 0) begin
         $display("idle_worker_dispatcher_top_test: clean");
      end else begin
         $display("idle_worker_dispatcher_top_test: errors");
      end
      $finish;
   end

endmodule
